// ===== rtl/rph_pkg.sv =====
// shared types and constants of the rolling polynomial hash unit
package rph_pkg;

  // field and register widths
  localparam int unsigned BASE_W    = 8;
  localparam int unsigned MODCFG_W  = 41;
  localparam int unsigned WLEN_W    = 7;
  localparam int unsigned NUC_W     = 2;
  localparam int unsigned HASH_W    = 41;
  localparam int unsigned CFG_IDX_W = 2;

  // stream data widths, padded to whole bytes
  localparam int unsigned S_TDATA_W = 8;
  localparam int unsigned M_TDATA_W = 48;

  // register reset values
  localparam logic [BASE_W-1:0]   BASE_RST = 8'd31;
  localparam logic [MODCFG_W-1:0] MOD_RST  = 41'd1099511627781;
  localparam logic [WLEN_W-1:0]   WLEN_RST = 7'd32;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BASE    = 2'd0,
    CFG_MODULUS = 2'd1,
    CFG_WLEN    = 2'd2
  } cfg_idx_e;

  // operations of the modular accumulator
  typedef enum logic [2:0] {
    MOP_HOLD   = 3'd0,
    MOP_CLEAR  = 3'd1,
    MOP_SHIFT  = 3'd2,
    MOP_DOUBLE = 3'd3,
    MOP_ADD    = 3'd4,
    MOP_NEG    = 3'd5
  } mop_e;

  typedef struct packed {
    mop_e op;
    logic din;
  } mop_ctl_t;

endpackage

// ===== rtl/rph_mod_unit.sv =====
// modular accumulator: one doubling, bit shift-in, addition, negation or clear per cycle, unless it holds
module rph_mod_unit #(
  parameter int unsigned MW = 41
) (
  input  logic              clk_i,
  input  rph_pkg::mop_ctl_t ctl_i,
  input  logic [MW-1:0]     addend_i,
  input  logic [MW-1:0]     mod_i,
  output logic [MW-1:0]     acc_o
);

  logic [MW-1:0] acc_q, acc_d;
  logic [MW:0]   sum_s;
  logic [MW:0]   red_s;

  // raw sum, always below twice the modulus
  always_comb begin
    case (ctl_i.op)
      rph_pkg::MOP_ADD:    sum_s = {1'b0, acc_q} + {1'b0, addend_i};
      rph_pkg::MOP_SHIFT:  sum_s = {acc_q, ctl_i.din};
      rph_pkg::MOP_DOUBLE: sum_s = {acc_q, 1'b0};
      default:             sum_s = '0;
    endcase
  end

  // single conditional subtract brings it back below the modulus
  assign red_s = (sum_s >= {1'b0, mod_i}) ? (sum_s - {1'b0, mod_i}) : sum_s;

  always_comb begin
    case (ctl_i.op)
      rph_pkg::MOP_CLEAR:  acc_d = '0;
      rph_pkg::MOP_NEG:    acc_d = mod_i - acc_q;
      rph_pkg::MOP_ADD,
      rph_pkg::MOP_SHIFT,
      rph_pkg::MOP_DOUBLE: acc_d = red_s[MW-1:0];
      default:             acc_d = acc_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  assign acc_o = acc_q;

endmodule

// ===== rtl/rolling_polynomial_hash_unit.sv =====
// top level of the rolling polynomial hash unit
// Rabin-Karp rolling hash over a window of window_length two-bit nucleotides modulo a
// runtime modulus. One transaction in gives one transaction out (hash in m_axis_tdata,
// window-full flag in m_axis_tuser). All modular arithmetic runs through one shared
// accumulator that does at most one add-and-reduce step per cycle, and the multiplies by
// base are shift-and-add over the 8 base bits, a doubling for every bit and an addition
// for each set bit. Each stored value (base, nucleotide, oldest symbol, hash, top power)
// that is not below the current modulus, as after a modulus change, goes through a serial
// reduction. The result sits in an output register, so the next item is taken while it
// waits. Symbols live in a WINDOW_MAX-entry circular buffer whose entries read as zero
// until written; no clearing pass is needed after reset.
module rolling_polynomial_hash_unit #(
  parameter int unsigned WINDOW_MAX = 64,
  parameter int unsigned MOD_WIDTH  = 41
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration write channel
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [rph_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [rph_pkg::MODCFG_W-1:0]    cfg_data_i,
  // input stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [rph_pkg::S_TDATA_W-1:0]   s_axis_tdata,  // [1:0] nucleotide
  input  logic                            s_axis_tuser,  // [0] cmd
  // output stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [rph_pkg::M_TDATA_W-1:0]   m_axis_tdata,  // [40:0] hash_value
  output logic                            m_axis_tuser   // [0] window_full
);

  localparam int unsigned MW   = MOD_WIDTH;
  localparam int unsigned AW   = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int unsigned CW   = $clog2(WINDOW_MAX + 1);
  localparam int unsigned SW   = CW + 1;
  localparam int unsigned CNTW = $clog2(MOD_WIDTH + 1);
  localparam int unsigned BW   = rph_pkg::BASE_W;
  localparam int unsigned NW   = rph_pkg::NUC_W;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CHK, ST_RED, ST_STORE, ST_MSET, ST_MUL,
    ST_ADDN, ST_HSAVE, ST_TSAVE, ST_NEG, ST_ADDH, ST_FIN
  } state_e;

  typedef enum logic [2:0] {
    TGT_BASE, TGT_NUC, TGT_OLD, TGT_HASH, TGT_TOP
  } tgt_e;

  typedef enum logic [1:0] {
    MUL_H, MUL_T, MUL_O
  } msel_e;

  // configuration registers
  logic [BW-1:0]                   cfg_base_q;
  logic [rph_pkg::MODCFG_W-1:0]    cfg_mod_q;
  logic [rph_pkg::WLEN_W-1:0]      cfg_wlen_q;

  // window state
  logic [MW-1:0]         hash_q, tp_q;
  logic [CW-1:0]         fill_q;
  logic [AW-1:0]         wp_q;
  logic [WINDOW_MAX-1:0] sym_vld_q;
  logic [NW-1:0]         symbol_mem [WINDOW_MAX];
  logic [NW-1:0]         old_data_q;
  logic                  old_vld_q;

  // sequencer
  state_e          state_q;
  tgt_e            tgt_q;
  msel_e           msel_q;
  logic            sub_q;
  logic [CNTW-1:0] cnt_q;
  logic [MW-1:0]   opnd_q;
  logic [BW-1:0]   mplr_q;
  logic [NW-1:0]   nuc_q;
  logic [BW-1:0]   b_q;
  logic [NW-1:0]   nr_q;
  logic [NW-1:0]   old_q;

  // output register
  logic                        out_valid_q;
  logic [rph_pkg::HASH_W-1:0]  out_hash_q;
  logic                        out_full_q;

  // derived values
  logic [63:0]           mod_ext;
  logic [MW-1:0]         m_raw, m_eff;
  logic [CW-1:0]         k_eff;
  logic                  roll;
  logic [SW-1:0]         rsum, rwrap;
  logic [AW-1:0]         raddr;
  logic [AW-1:0]         wp_nxt;
  logic [NW-1:0]         old_sym;
  logic [MW-1:0]         chk_val, store_val;
  logic                  need;
  logic                  s_accept, fin_go;
  logic [MW-1:0]         acc;
  logic [MW-1:0]         addend;
  rph_pkg::mop_ctl_t     ctl;
  logic [63:0]           hash_ext;

  // configuration writes
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_base_q <= rph_pkg::BASE_RST;
      cfg_mod_q  <= rph_pkg::MOD_RST;
      cfg_wlen_q <= rph_pkg::WLEN_RST;
    end else if (cfg_valid_i) begin
      case (rph_pkg::cfg_idx_e'(cfg_index_i))
        rph_pkg::CFG_BASE:    cfg_base_q <= cfg_data_i[BW-1:0];
        rph_pkg::CFG_MODULUS: cfg_mod_q  <= cfg_data_i;
        rph_pkg::CFG_WLEN:    cfg_wlen_q <= cfg_data_i[rph_pkg::WLEN_W-1:0];
        default: ;
      endcase
    end
  end

  // effective modulus, zero and one taken as one
  assign mod_ext = 64'(cfg_mod_q);
  assign m_raw   = mod_ext[MW-1:0];
  assign m_eff   = (m_raw < MW'(2)) ? MW'(1) : m_raw;

  // effective window length, clamped to 1..WINDOW_MAX
  always_comb begin
    if (cfg_wlen_q == '0) begin
      k_eff = CW'(1);
    end else if (32'(cfg_wlen_q) > WINDOW_MAX) begin
      k_eff = CW'(WINDOW_MAX);
    end else begin
      k_eff = CW'(cfg_wlen_q);
    end
  end

  assign roll = (fill_q >= k_eff);

  // oldest symbol sits k entries behind the write pointer
  assign rsum   = SW'(wp_q) + SW'(WINDOW_MAX) - SW'(k_eff);
  assign rwrap  = (rsum >= SW'(WINDOW_MAX)) ? (rsum - SW'(WINDOW_MAX)) : rsum;
  assign raddr  = rwrap[AW-1:0];
  assign wp_nxt = (wp_q == AW'(WINDOW_MAX - 1)) ? AW'(0) : (wp_q + 1'b1);

  assign old_sym = old_vld_q ? old_data_q : '0;

  // symbol buffer, read data registered
  always_ff @(posedge clk_i) begin
    if (fin_go) begin
      symbol_mem[wp_q] <= nuc_q;
    end
    old_data_q <= symbol_mem[raddr];
    old_vld_q  <= sym_vld_q[raddr];
  end

  // value under range check and its need for reduction
  always_comb begin
    case (tgt_q)
      TGT_BASE: chk_val = MW'(cfg_base_q);
      TGT_NUC:  chk_val = MW'(nuc_q);
      TGT_OLD:  chk_val = MW'(old_sym);
      TGT_HASH: chk_val = hash_q;
      TGT_TOP:  chk_val = tp_q;
      default:  chk_val = '0;
    endcase
  end

  assign need      = (chk_val >= m_eff);
  assign store_val = (state_q == ST_STORE) ? acc : chk_val;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign fin_go        = (state_q == ST_FIN) && (!out_valid_q || m_axis_tready);

  // accumulator control per state
  always_comb begin
    ctl    = '{op: rph_pkg::MOP_HOLD, din: 1'b0};
    addend = '0;
    case (state_q)
      ST_CHK: begin
        if (need) ctl.op = rph_pkg::MOP_CLEAR;
      end
      ST_RED: begin
        ctl.op  = rph_pkg::MOP_SHIFT;
        ctl.din = opnd_q[MW-1];
      end
      ST_MSET: ctl.op = rph_pkg::MOP_CLEAR;
      ST_MUL: begin
        ctl.op = sub_q ? rph_pkg::MOP_ADD : rph_pkg::MOP_DOUBLE;
        addend = (msel_q == MUL_H) ? hash_q : tp_q;
      end
      ST_ADDN: begin
        ctl.op = rph_pkg::MOP_ADD;
        addend = MW'(nr_q);
      end
      ST_NEG: ctl.op = rph_pkg::MOP_NEG;
      ST_ADDH: begin
        ctl.op = rph_pkg::MOP_ADD;
        addend = hash_q;
      end
      default: ;
    endcase
  end

  rph_mod_unit #(
    .MW (MW)
  ) u_mod (
    .clk_i    (clk_i),
    .ctl_i    (ctl),
    .addend_i (addend),
    .mod_i    (m_eff),
    .acc_o    (acc)
  );

  // sequencer, window state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      tgt_q       <= TGT_BASE;
      msel_q      <= MUL_H;
      sub_q       <= 1'b0;
      cnt_q       <= '0;
      hash_q      <= '0;
      tp_q        <= MW'(1);
      fill_q      <= '0;
      wp_q        <= '0;
      sym_vld_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // output register load and drain
      if (fin_go) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (s_accept) begin
            nuc_q <= s_axis_tdata[NW-1:0];
            if (s_axis_tuser) begin
              hash_q <= '0;
              tp_q   <= MW'(1);
              fill_q <= '0;
            end
            tgt_q   <= TGT_BASE;
            state_q <= ST_CHK;
          end
        end
        ST_CHK: begin
          if (need) begin
            opnd_q  <= chk_val;
            cnt_q   <= CNTW'(MW);
            state_q <= ST_RED;
          end
        end
        ST_RED: begin
          opnd_q <= opnd_q << 1;
          cnt_q  <= cnt_q - 1'b1;
          if (cnt_q == CNTW'(1)) state_q <= ST_STORE;
        end
        ST_STORE: ;
        ST_MSET: begin
          sub_q <= 1'b0;
          if (msel_q == MUL_O) begin
            mplr_q <= {old_q, {(BW - NW){1'b0}}};
            cnt_q  <= CNTW'(NW);
          end else begin
            mplr_q <= b_q;
            cnt_q  <= CNTW'(BW);
          end
          state_q <= ST_MUL;
        end
        ST_MUL: begin
          if (!sub_q && mplr_q[BW-1]) begin
            sub_q <= 1'b1;
          end else begin
            sub_q  <= 1'b0;
            mplr_q <= mplr_q << 1;
            cnt_q  <= cnt_q - 1'b1;
            if (cnt_q == CNTW'(1)) begin
              case (msel_q)
                MUL_H:   state_q <= ST_ADDN;
                MUL_T:   state_q <= ST_TSAVE;
                default: state_q <= ST_NEG;
              endcase
            end
          end
        end
        ST_ADDN: state_q <= ST_HSAVE;
        ST_HSAVE: begin
          hash_q <= acc;
          if (msel_q == MUL_H) begin
            msel_q  <= roll ? MUL_O : MUL_T;
            state_q <= ST_MSET;
          end else begin
            state_q <= ST_FIN;
          end
        end
        ST_TSAVE: begin
          tp_q    <= acc;
          fill_q  <= fill_q + 1'b1;
          state_q <= ST_FIN;
        end
        ST_NEG:  state_q <= ST_ADDH;
        ST_ADDH: state_q <= ST_HSAVE;
        ST_FIN: begin
          if (fin_go) begin
            out_hash_q      <= hash_ext[rph_pkg::HASH_W-1:0];
            out_full_q      <= (fill_q >= k_eff);
            sym_vld_q[wp_q] <= 1'b1;
            wp_q            <= wp_nxt;
            state_q         <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase

      // store a checked or reduced value and move to the next one
      if ((state_q == ST_CHK && !need) || state_q == ST_STORE) begin
        case (tgt_q)
          TGT_BASE: begin
            b_q     <= store_val[BW-1:0];
            tgt_q   <= TGT_NUC;
            state_q <= ST_CHK;
          end
          TGT_NUC: begin
            nr_q    <= store_val[NW-1:0];
            tgt_q   <= roll ? TGT_OLD : TGT_HASH;
            state_q <= ST_CHK;
          end
          TGT_OLD: begin
            old_q   <= store_val[NW-1:0];
            tgt_q   <= TGT_HASH;
            state_q <= ST_CHK;
          end
          TGT_HASH: begin
            hash_q  <= store_val;
            tgt_q   <= TGT_TOP;
            state_q <= ST_CHK;
          end
          default: begin
            tp_q    <= store_val;
            msel_q  <= MUL_H;
            state_q <= ST_MSET;
          end
        endcase
      end
    end
  end

  assign hash_ext = 64'(hash_q);

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(rph_pkg::M_TDATA_W - rph_pkg::HASH_W){1'b0}}, out_hash_q};
  assign m_axis_tuser  = out_full_q;

  // fill count never passes the buffer depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CW'(WINDOW_MAX))
    else $error("fill count beyond window depth");

  // a finishing item always lands in the output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_go |=> m_axis_tvalid)
    else $error("finished item not presented");

  // write pointer steps by one, wrapping at the buffer depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_go |=> (wp_q == (($past(wp_q) == AW'(WINDOW_MAX - 1)) ? AW'(0)
                                                              : ($past(wp_q) + 1'b1))))
    else $error("symbol write pointer out of step");

endmodule

// ===== test/rph_hash_checker.sv =====
// stream monitor with a window hash predictor and result comparison for the hash unit
module rph_hash_checker #(
  parameter int unsigned WINDOW_MAX = 64,
  parameter int unsigned MOD_WIDTH  = 41
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  input  logic                           cfg_ready_i,
  input  logic [rph_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [rph_pkg::MODCFG_W-1:0]   cfg_data_i,
  input  logic                           s_valid_i,
  input  logic                           s_ready_i,
  input  logic [rph_pkg::S_TDATA_W-1:0]  s_data_i,   // [1:0] nucleotide
  input  logic                           s_user_i,   // [0] cmd
  input  logic                           m_valid_i,
  input  logic                           m_ready_i,
  input  logic [rph_pkg::M_TDATA_W-1:0]  m_data_i,   // [40:0] hash_value
  input  logic                           m_user_i,   // [0] window_full
  output int                             error_count_o,
  output int                             result_count_o,
  output int                             outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [63:0] word_t;

  typedef struct packed {
    logic [rph_pkg::HASH_W-1:0] hash_value;
    logic                       window_full;
  } window_hash_t;

  // shadow configuration
  logic [rph_pkg::BASE_W-1:0]   base_reg;
  logic [rph_pkg::MODCFG_W-1:0] modulus_reg;
  logic [rph_pkg::WLEN_W-1:0]   wlen_reg;

  // shadow window state
  word_t       hash_acc;
  word_t       power_acc;
  int unsigned fill_cnt;
  logic [rph_pkg::NUC_W-1:0] sym_hist [WINDOW_MAX];

  window_hash_t expected_hashes [$];

  function automatic word_t add_m(input word_t a, input word_t b, input word_t m);
    word_t s;
    s = a + b;
    return (s >= m) ? s - m : s;
  endfunction

  function automatic word_t sub_m(input word_t a, input word_t b, input word_t m);
    return (a >= b) ? a - b : a + (m - b);
  endfunction

  // shift-and-add modular product, msb first
  function automatic word_t mul_m(input word_t a, input word_t b, input word_t m);
    word_t r;
    r = '0;
    for (int i = MOD_WIDTH - 1; i >= 0; i--) begin
      r = add_m(r, r, m);
      if (b[i]) r = add_m(r, a, m);
    end
    return r;
  endfunction

  // advance the shadow window by one nucleotide and return the expected result
  function automatic window_hash_t predict_window(input logic cmd,
                                                  input logic [rph_pkg::NUC_W-1:0] nuc);
    word_t m, k, b, n, h, tp, oldest;
    window_hash_t res;
    m = word_t'(modulus_reg) & ((word_t'(1) << MOD_WIDTH) - word_t'(1));
    if (m < 2) m = 1;
    k = word_t'(wlen_reg);
    if (k == 0) k = 1;
    if (k > WINDOW_MAX) k = WINDOW_MAX;
    b = word_t'(base_reg) % m;
    n = word_t'(nuc) % m;
    // start command empties the window
    if (cmd) begin
      hash_acc  = 0;
      power_acc = 1;
      fill_cnt  = 0;
    end
    h  = hash_acc % m;
    tp = power_acc % m;
    if (fill_cnt < k) begin
      h  = add_m(mul_m(h, b, m), n, m);
      tp = mul_m(tp, b, m);
      fill_cnt++;
    end else begin
      // full window: drop the oldest symbol weighted by base^k
      oldest = word_t'(sym_hist[k-1]) % m;
      h = add_m(mul_m(h, b, m), n, m);
      h = sub_m(h, mul_m(oldest, tp, m), m);
    end
    for (int i = WINDOW_MAX - 1; i > 0; i--) sym_hist[i] = sym_hist[i-1];
    sym_hist[0] = nuc;
    hash_acc  = h;
    power_acc = tp;
    if (fill_cnt > WINDOW_MAX) fill_cnt = WINDOW_MAX;
    res.hash_value  = h[rph_pkg::HASH_W-1:0];
    res.window_full = (fill_cnt >= k);
    return res;
  endfunction

  // watch all three channels
  always @(posedge clk_i or negedge rst_ni) begin : track
    window_hash_t want;
    int bad;
    if (!rst_ni) begin
      base_reg    = rph_pkg::BASE_RST;
      modulus_reg = rph_pkg::MOD_RST;
      wlen_reg    = rph_pkg::WLEN_RST;
      hash_acc    = 0;
      power_acc   = 1;
      fill_cnt    = 0;
      for (int i = 0; i < WINDOW_MAX; i++) sym_hist[i] = '0;
      expected_hashes.delete();
      error_count_o  <= 0;
      result_count_o <= 0;
      outstanding_o  <= 0;
    end else begin
      bad = 0;
      // register write transaction
      if (cfg_valid_i && cfg_ready_i) begin
        case (rph_pkg::cfg_idx_e'(cfg_index_i))
          rph_pkg::CFG_BASE:    base_reg    = cfg_data_i[rph_pkg::BASE_W-1:0];
          rph_pkg::CFG_MODULUS: modulus_reg = cfg_data_i;
          rph_pkg::CFG_WLEN:    wlen_reg    = cfg_data_i[rph_pkg::WLEN_W-1:0];
          default: ;
        endcase
      end
      // result transaction against the oldest expectation
      if (m_valid_i && m_ready_i) begin
        if (expected_hashes.size() == 0) begin
          $error("unexpected result transaction: hash_value %0d window_full %0b",
                 m_data_i[rph_pkg::HASH_W-1:0], m_user_i);
          bad++;
        end else begin
          want = expected_hashes.pop_front();
          if (m_data_i[rph_pkg::HASH_W-1:0] !== want.hash_value) begin
            $error("hash_value mismatch: expected %0d, actual %0d",
                   want.hash_value, m_data_i[rph_pkg::HASH_W-1:0]);
            bad++;
          end
          if (m_user_i !== want.window_full) begin
            $error("window_full mismatch: expected %0b, actual %0b",
                   want.window_full, m_user_i);
            bad++;
          end
        end
        result_count_o <= result_count_o + 1;
      end
      // input transaction
      if (s_valid_i && s_ready_i)
        expected_hashes.push_back(predict_window(s_user_i, s_data_i[rph_pkg::NUC_W-1:0]));
      error_count_o <= error_count_o + bad;
      outstanding_o <= expected_hashes.size();
    end
  end

endmodule

// ===== test/tb_rolling_polynomial_hash_unit.sv =====
// top of the hash unit testbench: clock, reset, stimulus, back-pressure and verdict
module tb_rolling_polynomial_hash_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ITEM_TARGET = 1700;
  localparam int unsigned IDLE_LIMIT  = 4000;
  localparam int unsigned TAIL_CYCLES = 60;

  typedef logic [rph_pkg::MODCFG_W-1:0] cfg_word_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [rph_pkg::CFG_IDX_W-1:0] cfg_index;
  cfg_word_t                     cfg_data;
  logic                          s_tvalid;
  logic                          s_tready;
  logic [rph_pkg::S_TDATA_W-1:0] s_tdata;
  logic                          s_tuser;
  logic                          m_tvalid;
  logic                          m_tready;
  logic [rph_pkg::M_TDATA_W-1:0] m_tdata;
  logic                          m_tuser;

  int          fail_cnt;
  int          results_seen;
  int          outstanding;
  int          items_sent = 0;
  int unsigned idle_cycles = 0;
  bit          no_gaps = 1'b0;

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  rolling_polynomial_hash_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tuser  (m_tuser)
  );

  rph_hash_checker i_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_i    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .s_valid_i      (s_tvalid),
    .s_ready_i      (s_tready),
    .s_data_i       (s_tdata),
    .s_user_i       (s_tuser),
    .m_valid_i      (m_tvalid),
    .m_ready_i      (m_tready),
    .m_data_i       (m_tdata),
    .m_user_i       (m_tuser),
    .error_count_o  (fail_cnt),
    .result_count_o (results_seen),
    .outstanding_o  (outstanding)
  );

  // register write transaction; valid stays high until the next nucleotide transaction begins
  task automatic write_reg(input rph_pkg::cfg_idx_e idx, input cfg_word_t value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk_i); while (!cfg_ready);
  endtask

  // one nucleotide transaction after a random gap
  task automatic send_item(input logic cmd, input logic [rph_pkg::NUC_W-1:0] nuc);
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(0, 4);
    cfg_valid <= 1'b0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= rph_pkg::S_TDATA_W'(nuc);
    s_tuser  <= cmd;
    do @(posedge clk_i); while (!s_tready);
    items_sent++;
  endtask

  // stop sending and wait for every hash to come back
  task automatic settle();
    s_tvalid <= 1'b0;
    while (results_seen != items_sent) @(posedge clk_i);
  endtask

  // result side back-pressure
  initial begin
    int unsigned stall;
    m_tready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_tready <= 1'b1;
      do @(posedge clk_i); while (!m_tvalid);
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // stimulus and verdict
  initial begin
    logic [63:0] junk;
    cfg_word_t   value;
    int unsigned sel;
    int unsigned count;
    rst_ni    <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings, appends before any start
    send_item(1'b0, 2'd0);
    send_item(1'b0, 2'd3);
    send_item(1'b1, 2'd2);
    send_item(1'b0, 2'd1);
    settle();
    // one-symbol window with the largest base and modulus
    write_reg(rph_pkg::CFG_WLEN, cfg_word_t'(1));
    write_reg(rph_pkg::CFG_BASE, cfg_word_t'(255));
    write_reg(rph_pkg::CFG_MODULUS, '1);
    send_item(1'b1, 2'd3);
    send_item(1'b0, 2'd3);
    send_item(1'b0, 2'd0);
    send_item(1'b0, 2'd3);
    settle();
    // zero window length behaves as one
    write_reg(rph_pkg::CFG_WLEN, cfg_word_t'(0));
    send_item(1'b0, 2'd2);
    send_item(1'b1, 2'd1);
    settle();
    // oversized window with degenerate moduli
    write_reg(rph_pkg::CFG_WLEN, cfg_word_t'(127));
    write_reg(rph_pkg::CFG_MODULUS, cfg_word_t'(0));
    send_item(1'b1, 2'd3);
    send_item(1'b0, 2'd2);
    settle();
    write_reg(rph_pkg::CFG_MODULUS, cfg_word_t'(1));
    send_item(1'b0, 2'd1);
    settle();
    // base and symbols not below a tiny modulus
    write_reg(rph_pkg::CFG_MODULUS, cfg_word_t'(3));
    write_reg(rph_pkg::CFG_BASE, cfg_word_t'(255));
    send_item(1'b1, 2'd3);
    send_item(1'b0, 2'd3);
    send_item(1'b0, 2'd2);
    settle();
    // bases zero and one
    write_reg(rph_pkg::CFG_BASE, cfg_word_t'(0));
    write_reg(rph_pkg::CFG_MODULUS, cfg_word_t'(5));
    write_reg(rph_pkg::CFG_WLEN, cfg_word_t'(2));
    send_item(1'b1, 2'd1);
    send_item(1'b0, 2'd3);
    send_item(1'b0, 2'd2);
    settle();
    write_reg(rph_pkg::CFG_BASE, cfg_word_t'(1));
    send_item(1'b0, 2'd1);
    settle();

    // random phases: new settings, then mostly started windows that fill and roll
    while (items_sent < ITEM_TARGET) begin
      no_gaps = ($urandom_range(0, 3) == 0);
      sel     = $urandom_range(1, 7);
      junk    = {$urandom, $urandom};
      if (sel[0]) begin
        case ($urandom_range(0, 5))
          0:       value = cfg_word_t'($urandom_range(0, 1));
          1:       value = cfg_word_t'(255);
          2:       value = cfg_word_t'(2);
          default: value = cfg_word_t'($urandom_range(2, 255));
        endcase
        if ($urandom_range(0, 3) == 0)
          value[rph_pkg::MODCFG_W-1:rph_pkg::BASE_W] =
            junk[rph_pkg::MODCFG_W-1:rph_pkg::BASE_W];
        write_reg(rph_pkg::CFG_BASE, value);
      end
      if (sel[1]) begin
        case ($urandom_range(0, 9))
          0:       value = rph_pkg::MOD_RST;
          1:       value = '1;
          2:       value = cfg_word_t'($urandom_range(0, 2));
          3, 4:    value = cfg_word_t'($urandom_range(3, 1000));
          default: value = junk[rph_pkg::MODCFG_W-1:0] >> $urandom_range(0, 24);
        endcase
        write_reg(rph_pkg::CFG_MODULUS, value);
      end
      if (sel[2]) begin
        case ($urandom_range(0, 15))
          0:       value = cfg_word_t'(0);
          1:       value = cfg_word_t'($urandom_range(65, 127));
          2, 3:    value = cfg_word_t'($urandom_range(33, 64));
          4:       value = cfg_word_t'(64);
          default: value = cfg_word_t'($urandom_range(1, 12));
        endcase
        if ($urandom_range(0, 3) == 0)
          value[rph_pkg::MODCFG_W-1:rph_pkg::WLEN_W] =
            junk[rph_pkg::MODCFG_W-1:rph_pkg::WLEN_W];
        write_reg(rph_pkg::CFG_WLEN, value);
      end
      count = $urandom_range(10, 90);
      for (int i = 0; i < count; i++)
        send_item((i == 0) ? ($urandom_range(0, 4) != 0) : ($urandom_range(0, 24) == 0),
                  rph_pkg::NUC_W'($urandom_range(0, 3)));
      settle();
    end

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_cnt == 0 && outstanding == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
